/* src/bsde_pkg.sv */
// Shared constants and types for the B-spline de Boor evaluator.
package bsde_pkg;

   localparam int MAX_CTRL_POINTS = 64;
   localparam int MAX_ORDER       = 5;
   localparam int VALUE_WIDTH     = 32;

   localparam int FIELD_WIDTH = 32;
   localparam int KIND_WIDTH  = 2;
   localparam int SLOT_WIDTH  = 7;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH = 7;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LOAD_CTRL = 2'd0,
      KIND_LOAD_KNOT = 2'd1,
      KIND_EVALUATE  = 2'd2,
      KIND_UNUSED    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SPLINE_ORDER = 1'd0,
      CSR_CTRL_COUNT   = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [SLOT_WIDTH-1:0]  slot_index;
      logic [FIELD_WIDTH-1:0] coord_x;
      logic [FIELD_WIDTH-1:0] coord_y;
      logic [FIELD_WIDTH-1:0] coord_z;
      logic [FIELD_WIDTH-1:0] knot_time;
      logic [FIELD_WIDTH-1:0] query_time;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] point_x;
      logic [FIELD_WIDTH-1:0] point_y;
      logic [FIELD_WIDTH-1:0] point_z;
      logic [SLOT_WIDTH-1:0]  span_index;
      logic                   zero_gap;
   } rsp_word_type;

   // Divider control between sequencer and shared divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

/* src/bsde_if.sv */
// Valid/ready channel interface carrying one word.
interface bsde_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

/* src/bspline_de_boor_evaluator_unit.sv */
// Top level of the B-spline de Boor evaluator.
// Load words are taken while idle and keep ready high; an evaluate word holds ready
// low through the clamp, a span search of about log2(count) steps, the control point
// loads and the de Boor triangle, one divide per alpha; a zero knot gap skips it. The
// one shared bit-serial divider (NW = VALUE_WIDTH+18 bits) dominates; the output step also waits
// for an unaccepted result word. Synchronous reset sets degree 3, count 4; stores undefined.
module bspline_de_boor_evaluator_unit #(
   parameter int MAX_CTRL_POINTS = bsde_pkg::MAX_CTRL_POINTS,
   parameter int MAX_ORDER       = bsde_pkg::MAX_ORDER,
   parameter int VALUE_WIDTH     = bsde_pkg::VALUE_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [bsde_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [bsde_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   bsde_if.sink   req,
   bsde_if.source rsp
);
   bsde_seq #(.MAX_CTRL_POINTS(MAX_CTRL_POINTS), .MAX_ORDER(MAX_ORDER),
      .VALUE_WIDTH(VALUE_WIDTH)) u_seq (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req, .rsp);
endmodule

/* src/bsde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bsde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* src/bsde_div.sv */
// Radix-2 restoring divider for signed quotients, one quotient bit per cycle.
module bsde_div #(
   parameter int NUM_WIDTH = 50,
   parameter int DEN_WIDTH = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_WIDTH-1:0] numer,
   input  logic signed [DEN_WIDTH-1:0] denom,
   output logic                        busy,
   output logic                        done,
   output logic signed [NUM_WIDTH-1:0] quot
);
   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] q_ff, q_in;
   logic [DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] dmag_ff, dmag_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_WIDTH:0]   trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_WIDTH-1:0], q_ff[NUM_WIDTH-1]};
      if (start) begin
         q_in    = numer[NUM_WIDTH-1] ? NUM_WIDTH'(-numer) : numer;
         dmag_in = denom[DEN_WIDTH-1] ? DEN_WIDTH'(-denom) : denom;
         neg_in  = numer[NUM_WIDTH-1] ^ denom[DEN_WIDTH-1];
         rem_in  = '0;
         cnt_in  = CW'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = trial - {1'b0, dmag_ff};
            q_in   = {q_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? NUM_WIDTH'(-q_ff) : q_ff;
endmodule

/* src/bsde_seq.sv */
// Sequencer: loads, clamp, span search and de Boor triangle around one divider.
module bsde_seq #(
   parameter int MAX_CTRL_POINTS = bsde_pkg::MAX_CTRL_POINTS,
   parameter int MAX_ORDER       = bsde_pkg::MAX_ORDER,
   parameter int VALUE_WIDTH     = bsde_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [bsde_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [bsde_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   bsde_if.sink                   req,
   bsde_if.source                 rsp
);
   localparam int FW = bsde_pkg::FIELD_WIDTH;
   localparam int SW = bsde_pkg::SLOT_WIDTH;
   localparam int KNOT_DEPTH = MAX_CTRL_POINTS + MAX_ORDER + 1;
   localparam int CA = $clog2(MAX_CTRL_POINTS);
   localparam int KA = $clog2(KNOT_DEPTH);
   localparam int IW = $clog2(KNOT_DEPTH + 1) + 1;  // signed index width
   localparam int DW = VALUE_WIDTH + 2;             // difference width
   localparam int NW = VALUE_WIDTH + 18;            // alpha numerator width
   localparam int PW = $clog2(MAX_ORDER + 1);
   localparam int OW = 3;
   localparam int AW = 18;
   localparam int MW = AW + DW;
   localparam logic signed [DW-1:0] VMAX = DW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
   localparam logic signed [DW-1:0] VMIN = -VMAX - DW'(1);
   localparam logic [OW-1:0] MAXO = OW'(MAX_ORDER);

   typedef enum logic [4:0] {
      S_IDLE, S_LO_RD, S_LO_WT, S_HI_RD, S_HI_WT, S_CLAMP,
      S_SR_CHK, S_SR_CWT, S_SR_MID, S_SR_MWT,
      S_LD_RD, S_LD_WT, S_TLO_RD, S_TLO_WT, S_THI_RD, S_THI_WT,
      S_DIV, S_DIV_WT, S_UPD, S_OUT
   } state_type;

   state_type state_ff;
   logic [OW-1:0] order_ff;
   logic [SW-1:0] count_ff;
   logic [PW-1:0] p_ff;
   logic signed [IW-1:0] k_ff, end_ff, mid_ff, i_ff, r_ff;
   logic signed [DW-1:0] ub_ff, lo_ff, tlo_ff;
   logic signed [DW-1:0] dx_ff [MAX_ORDER+1];
   logic signed [DW-1:0] dy_ff [MAX_ORDER+1];
   logic signed [DW-1:0] dz_ff [MAX_ORDER+1];
   logic signed [AW-1:0] alpha_ff;
   logic [1:0] c_ff;
   logic zgap_ff;
   logic rsp_valid_ff;
   bsde_pkg::rsp_word_type rsp_word_ff;

   // Store ports
   logic c_we, k_we;
   logic [CA-1:0] c_wa, c_ra;
   logic [KA-1:0] k_wa, k_ra;
   logic [FW-1:0] x_rd, y_rd, z_rd, k_rd;
   logic [IW-1:0] c_ra_w, k_ra_w;

   function automatic logic [FW-1:0] store_sat(input logic [FW-1:0] v);
      logic signed [DW-1:0] s;
      s = DW'($signed(v));
      if (s > VMAX) s = VMAX;
      if (s < VMIN) s = VMIN;
      return FW'(s);
   endfunction

   function automatic logic signed [DW-1:0] sat(input logic signed [DW:0] v);
      if (v > (DW+1)'(VMAX)) return VMAX;
      if (v < (DW+1)'(VMIN)) return VMIN;
      return DW'(v);
   endfunction

   bsde_pkg::req_word_type rq;
   assign rq = req.word;
   wire accept = req.valid && req.ready;

   assign c_we = accept && rq.kind == bsde_pkg::KIND_LOAD_CTRL
                 && rq.slot_index < SW'(MAX_CTRL_POINTS);
   assign k_we = accept && rq.kind == bsde_pkg::KIND_LOAD_KNOT
                 && rq.slot_index < SW'(KNOT_DEPTH);
   assign c_wa = CA'(rq.slot_index);
   assign k_wa = KA'(rq.slot_index);
   assign c_ra = CA'(c_ra_w);
   assign k_ra = KA'(k_ra_w);

   bsde_ram #(.WIDTH(FW), .DEPTH(MAX_CTRL_POINTS)) u_x (.clock, .wr_en(c_we),
      .wr_addr(c_wa), .wr_data(store_sat(rq.coord_x)), .rd_addr(c_ra), .rd_data(x_rd));
   bsde_ram #(.WIDTH(FW), .DEPTH(MAX_CTRL_POINTS)) u_y (.clock, .wr_en(c_we),
      .wr_addr(c_wa), .wr_data(store_sat(rq.coord_y)), .rd_addr(c_ra), .rd_data(y_rd));
   bsde_ram #(.WIDTH(FW), .DEPTH(MAX_CTRL_POINTS)) u_z (.clock, .wr_en(c_we),
      .wr_addr(c_wa), .wr_data(store_sat(rq.coord_z)), .rd_addr(c_ra), .rd_data(z_rd));
   bsde_ram #(.WIDTH(FW), .DEPTH(KNOT_DEPTH)) u_k (.clock, .wr_en(k_we),
      .wr_addr(k_wa), .wr_data(store_sat(rq.knot_time)), .rd_addr(k_ra), .rd_data(k_rd));

   logic signed [DW-1:0] krd_s;
   assign krd_s = DW'($signed(k_rd));

   // Effective degree and count.
   logic [OW-1:0] p_eff;
   logic [SW:0]   cnt_eff;
   always_comb begin
      p_eff = order_ff;
      if (p_eff == '0) p_eff = OW'(1);
      if (p_eff > MAXO) p_eff = MAXO;
      cnt_eff = (SW+1)'(count_ff);
      if (cnt_eff > (SW+1)'(MAX_CTRL_POINTS)) cnt_eff = (SW+1)'(MAX_CTRL_POINTS);
      if (cnt_eff < (SW+1)'(p_eff) + 1'b1) cnt_eff = (SW+1)'(p_eff) + 1'b1;
   end

   // Divider.
   bsde_pkg::div_ctl_type dctl;
   logic signed [NW-1:0] numer, quot;
   logic signed [DW-1:0] den;
   assign numer = NW'(ub_ff - tlo_ff) <<< 16;
   assign den   = krd_s - tlo_ff;
   assign dctl.start = (state_ff == S_DIV) && den != '0;
   bsde_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div (.clock, .reset,
      .start(dctl.start), .numer, .denom(den),
      .busy(dctl.busy), .done(dctl.done), .quot);

   // Read addresses. The store output is registered, so an address is held
   // through the cycle before the one that consumes its data.
   logic signed [IW-1:0] p_s;
   assign p_s = IW'(p_ff);
   always_comb begin
      k_ra_w = '0;
      case (state_ff)
         S_LO_RD:  k_ra_w = p_s;
         S_HI_RD, S_HI_WT: k_ra_w = end_ff;
         S_SR_CHK: k_ra_w = k_ff + 1'b1;
         S_SR_MID: k_ra_w = mid_ff;
         S_TLO_RD: k_ra_w = i_ff + k_ff - p_s;
         S_THI_RD, S_THI_WT: k_ra_w = i_ff + 1'b1 + k_ff - r_ff;
         default:  k_ra_w = '0;
      endcase
      c_ra_w = k_ff - p_s + i_ff;
   end

   // Multiply-and-round for one coordinate.
   logic signed [DW-1:0] d_hi, d_lo;
   logic signed [DW:0]   diff;
   logic signed [MW:0]   prod;
   logic signed [DW:0]   stepv;
   always_comb begin
      case (c_ff)
         2'd0: begin d_hi = dx_ff[i_ff[PW-1:0]]; d_lo = dx_ff[PW'(i_ff - 1'b1)]; end
         2'd1: begin d_hi = dy_ff[i_ff[PW-1:0]]; d_lo = dy_ff[PW'(i_ff - 1'b1)]; end
         default: begin d_hi = dz_ff[i_ff[PW-1:0]]; d_lo = dz_ff[PW'(i_ff - 1'b1)]; end
      endcase
      diff  = (DW+1)'(d_hi) - (DW+1)'(d_lo);
      prod  = (MW+1)'(alpha_ff) * (MW+1)'(diff) + (MW+1)'(32768);
      stepv = (DW+1)'(prod >>> 16);
   end
   logic signed [DW-1:0] dnew;
   assign dnew = sat((DW+1)'(d_lo) + stepv);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= OW'(3);
         count_ff     <= SW'(4);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bsde_pkg::CSR_SPLINE_ORDER: order_ff <= csr_data[OW-1:0];
               bsde_pkg::CSR_CTRL_COUNT:   count_ff <= csr_data;
               default: ;
            endcase
         end
         // In S_OUT the valid flag is set below whenever the old word leaves.
         if (rsp.valid && rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept && rq.kind == bsde_pkg::KIND_EVALUATE) begin
               p_ff    <= PW'(p_eff);
               end_ff  <= IW'(cnt_eff);
               ub_ff   <= sat((DW+1)'($signed(rq.query_time)));
               zgap_ff <= 1'b0;
               state_ff <= S_LO_RD;
            end
            S_LO_RD: state_ff <= S_LO_WT;
            S_LO_WT: begin lo_ff <= krd_s; state_ff <= S_HI_RD; end
            S_HI_RD: state_ff <= S_HI_WT;
            S_HI_WT: begin
               if (ub_ff < lo_ff) ub_ff <= lo_ff;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               if (ub_ff > krd_s) ub_ff <= krd_s;
               k_ff <= p_s;
               state_ff <= S_SR_CHK;
            end
            S_SR_CHK: state_ff <= S_SR_CWT;
            S_SR_CWT: begin
               if (k_ff + 1'b1 <= end_ff && krd_s < ub_ff) begin
                  mid_ff   <= IW'((k_ff + end_ff) >>> 1);
                  state_ff <= S_SR_MID;
               end else begin
                  i_ff <= '0;
                  state_ff <= S_LD_RD;
               end
            end
            S_SR_MID: state_ff <= S_SR_MWT;
            S_SR_MWT: begin
               if (krd_s > ub_ff) end_ff <= mid_ff;
               else k_ff <= mid_ff;
               state_ff <= S_SR_CHK;
            end
            S_LD_RD: state_ff <= S_LD_WT;
            S_LD_WT: begin
               dx_ff[i_ff[PW-1:0]] <= DW'($signed(x_rd));
               dy_ff[i_ff[PW-1:0]] <= DW'($signed(y_rd));
               dz_ff[i_ff[PW-1:0]] <= DW'($signed(z_rd));
               if (i_ff == p_s) begin
                  r_ff <= IW'(1);
                  i_ff <= p_s;
                  state_ff <= S_TLO_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_LD_RD;
               end
            end
            S_TLO_RD: state_ff <= S_TLO_WT;
            S_TLO_WT: begin tlo_ff <= krd_s; state_ff <= S_THI_RD; end
            S_THI_RD: state_ff <= S_THI_WT;
            S_THI_WT: state_ff <= S_DIV;
            S_DIV: begin
               c_ff <= 2'd0;
               if (den == '0) begin
                  alpha_ff <= '0;
                  zgap_ff  <= 1'b1;
                  state_ff <= S_UPD;
               end else begin
                  state_ff <= S_DIV_WT;
               end
            end
            S_DIV_WT: if (dctl.done) begin
               if (quot < 0) alpha_ff <= '0;
               else if (quot > NW'(65536)) alpha_ff <= AW'(65536);
               else alpha_ff <= AW'(quot);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               case (c_ff)
                  2'd0: dx_ff[i_ff[PW-1:0]] <= dnew;
                  2'd1: dy_ff[i_ff[PW-1:0]] <= dnew;
                  default: dz_ff[i_ff[PW-1:0]] <= dnew;
               endcase
               if (c_ff != 2'd2) begin
                  c_ff <= c_ff + 1'b1;
               end else if (i_ff > r_ff) begin
                  i_ff <= i_ff - 1'b1;
                  state_ff <= S_TLO_RD;
               end else if (r_ff < p_s) begin
                  r_ff <= r_ff + 1'b1;
                  i_ff <= p_s;
                  state_ff <= S_TLO_RD;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_word_ff.point_x    <= FW'(dx_ff[p_ff]);
               rsp_word_ff.point_y    <= FW'(dy_ff[p_ff]);
               rsp_word_ff.point_z    <= FW'(dz_ff[p_ff]);
               rsp_word_ff.span_index <= SW'(k_ff);
               rsp_word_ff.zero_gap   <= zgap_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;
endmodule

/* src/bsde_checker.sv */
// Port-level checker for the evaluator, bound to the top level.
module bsde_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_kind,
   input logic rsp_valid,
   input logic rsp_ready
);
   // An evaluate word drops ready on the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == bsde_pkg::KIND_EVALUATE |=> !req_ready)
      else $error("ready stayed high after evaluate");
   // A load word leaves the block ready.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind != bsde_pkg::KIND_EVALUATE |=> req_ready)
      else $error("ready dropped after load");
   // A result appears only as ready returns.
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && !$past(req_ready))
      else $error("result without finishing evaluation");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
endmodule

bind bspline_de_boor_evaluator_unit bsde_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready), .req_kind(req.word.kind),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready));
